>>> rtl/core/lfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

    // Default widths of the sample and of the fraction of the delay.
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF    = 14;

    // The delay input field is always 16 bits wide.
    localparam int FRAC_IN_W = 16;

    // Digit size of the serial multiplier.
    localparam int DIGIT_W = 4;

    localparam int RING_DEPTH  = 5;
    localparam int PTR_W       = 3;
    localparam int PRIME_COUNT = 3;
    localparam int FILL_W      = 2;

    // Rounding bias and shift of each scaling; a divide by three follows for 24 and 6.
    localparam int DIV24_BIAS  = 12;
    localparam int DIV24_SHIFT = 3;
    localparam int DIV6_BIAS   = 3;
    localparam int DIV6_SHIFT  = 1;
    localparam int DIV4_BIAS   = 2;
    localparam int DIV4_SHIFT  = 2;

    localparam int UOP_COUNT = 12;
    localparam int STEP_W    = 4;
    localparam int K_W       = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ROUND,
        ST_SCALE,
        ST_DIV_WAIT,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_ACC,
        ST_BIAS,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        ASRC_RUN,
        ASRC_D,
        ASRC_P01,
        ASRC_P012
    } t_asrc;

    typedef enum logic [1:0] {
        SAVE_NONE,
        SAVE_P01,
        SAVE_P012
    } t_save;

    typedef enum logic [1:0] {
        SCALE_DIV24,
        SCALE_DIV6_NEG,
        SCALE_DIV4
    } t_scale;

    // One step of the weight sequence. The first step of a chain loads the
    // A operand from asrc/a_k; later steps reuse the previous rounded product.
    typedef struct packed {
        logic           first;
        t_asrc          asrc;
        logic [K_W-1:0] a_k;
        logic [K_W-1:0] b_k;
        t_save          save;
        logic           last;
        t_scale         scale;
        logic [K_W-1:0] weight;
    } t_uop;

    // Chains: h4 = d0*d1*d2*d3, h3 = (d0*d1*d2)*d4, h2 = (d0*d1)*d3*d4,
    // h1 = d0*d2*d3*d4, h0 = d1*d2*d3*d4. Shared partial products are saved.
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{1'b0, ASRC_RUN, 3'd0, 3'd0, SAVE_NONE, 1'b0, SCALE_DIV24, 3'd0};
        unique case (step)
            4'd0:  u = '{1'b1, ASRC_D,    3'd0, 3'd1, SAVE_P01,  1'b0, SCALE_DIV24,    3'd4};
            4'd1:  u = '{1'b0, ASRC_RUN,  3'd0, 3'd2, SAVE_P012, 1'b0, SCALE_DIV24,    3'd4};
            4'd2:  u = '{1'b0, ASRC_RUN,  3'd0, 3'd3, SAVE_NONE, 1'b1, SCALE_DIV24,    3'd4};
            4'd3:  u = '{1'b1, ASRC_P012, 3'd0, 3'd4, SAVE_NONE, 1'b1, SCALE_DIV6_NEG, 3'd3};
            4'd4:  u = '{1'b1, ASRC_P01,  3'd0, 3'd3, SAVE_NONE, 1'b0, SCALE_DIV4,     3'd2};
            4'd5:  u = '{1'b0, ASRC_RUN,  3'd0, 3'd4, SAVE_NONE, 1'b1, SCALE_DIV4,     3'd2};
            4'd6:  u = '{1'b1, ASRC_D,    3'd0, 3'd2, SAVE_NONE, 1'b0, SCALE_DIV6_NEG, 3'd1};
            4'd7:  u = '{1'b0, ASRC_RUN,  3'd0, 3'd3, SAVE_NONE, 1'b0, SCALE_DIV6_NEG, 3'd1};
            4'd8:  u = '{1'b0, ASRC_RUN,  3'd0, 3'd4, SAVE_NONE, 1'b1, SCALE_DIV6_NEG, 3'd1};
            4'd9:  u = '{1'b1, ASRC_D,    3'd1, 3'd2, SAVE_NONE, 1'b0, SCALE_DIV24,    3'd0};
            4'd10: u = '{1'b0, ASRC_RUN,  3'd0, 3'd3, SAVE_NONE, 1'b0, SCALE_DIV24,    3'd0};
            4'd11: u = '{1'b0, ASRC_RUN,  3'd0, 3'd4, SAVE_NONE, 1'b1, SCALE_DIV24,    3'd0};
            default: u = '{1'b0, ASRC_RUN, 3'd0, 3'd0, SAVE_NONE, 1'b0, SCALE_DIV24, 3'd0};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lfd_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module lfd_serial_mul #(
    parameter int OP_W = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [OP_W-1:0]   i_a,
    input  wire logic signed [OP_W-1:0]   i_b,
    output logic                          o_done,
    output logic signed [2*OP_W-1:0]      o_product
);
    import lfd_pkg::*;

    localparam int NUM_DIG = (OP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MB_W    = NUM_DIG * DIGIT_W;
    localparam int PW      = OP_W + MB_W;
    localparam int CNT_W   = $clog2(NUM_DIG + 1);

    logic signed [PW-1:0]      r_mcand;
    logic signed [PW-1:0]      r_acc;
    logic [MB_W-1:0]           r_mplier;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;

    logic                      w_top;
    logic signed [DIGIT_W:0]   w_digit;
    logic signed [PW+DIGIT_W:0] w_partial;

    // The most significant digit carries the sign of the multiplier.
    assign w_top   = (r_cnt == CNT_W'(1));
    assign w_digit = w_top ? $signed({r_mplier[DIGIT_W-1], r_mplier[DIGIT_W-1:0]})
                           : $signed({1'b0, r_mplier[DIGIT_W-1:0]});
    assign w_partial = r_mcand * w_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_top;
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_DIG);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= PW'(i_a);
            r_mplier <= MB_W'(i_b);
            r_acc    <= '0;
        end else if (r_cnt != '0) begin
            r_acc    <= r_acc + $signed(w_partial[PW-1:0]);
            r_mcand  <= r_mcand <<< DIGIT_W;
            r_mplier <= r_mplier >> DIGIT_W;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc[2*OP_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/lfd_div3.sv
`timescale 1ns / 1ps
`default_nettype none

module lfd_div3 #(
    parameter int OP_W = 25
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [OP_W-1:0] i_dividend,
    output logic                        o_done,
    output logic signed [OP_W-1:0]      o_quotient
);
    localparam int NUM_W = OP_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // Adding three times half the range makes the dividend non-negative, so a
    // plain long division gives the floor; the offset divided by three is
    // removed at the end.
    localparam logic [NUM_W-1:0] OFFSET   = NUM_W'(3) << (OP_W - 1);
    localparam logic [NUM_W-1:0] Q_OFFSET = NUM_W'(1) << (OP_W - 1);

    logic [NUM_W-1:0] r_num;
    logic [1:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [2:0]       w_trial;
    logic             w_ge;
    logic [NUM_W-1:0] w_q;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= 3'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // One quotient bit per cycle shifts in from the bottom as the dividend
    // bits leave at the top.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'(i_dividend) + OFFSET;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? 2'(w_trial - 3'd3) : w_trial[1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    assign w_q        = r_num - Q_OFFSET;
    assign o_quotient = $signed(w_q[OP_W-1:0]);
    assign o_done     = r_done;

endmodule

`default_nettype wire

>>> rtl/core/lagrange_fractional_delay.sv
// Before four samples are held, an accepted transaction yields a zero result with tuser
// low; after that each transaction runs the full filter on the 4-bit-digit serial
// multiplier (17 products) and the bit-serial divide by three (four quotients). The input
// is ready only while idle, so no new sample is taken until the last result is loaded
// into the output register; output stalls hold that load back. OPW is the internal
// operand width. Reset (synchronous, active low) clears the sample ring, pointer,
// fill count, step, state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module lagrange_fractional_delay #(
    parameter int SAMPLE_WIDTH = lfd_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = lfd_pkg::FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    // sample_in, frac_delay, zero padding
    input  wire logic [((SAMPLE_WIDTH + lfd_pkg::FRAC_IN_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    // sample_out, zero padding
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,
    // primed
    output logic      o_m_tuser
);
    import lfd_pkg::*;

    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int MAG_W   = (FRAC_IN_W > FRAC_BITS + 2) ? FRAC_IN_W : FRAC_BITS + 2;
    localparam int CHAIN_W = 4 * MAG_W - 3 * FRAC_BITS + 2;
    localparam int OP_W    = (CHAIN_W > SAMPLE_WIDTH + 1) ? CHAIN_W : SAMPLE_WIDTH + 1;
    localparam int PROD_W  = 2 * OP_W;
    localparam int ACC_W   = PROD_W + 3;

    localparam logic signed [OP_W-1:0]   ONE_OP = OP_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  HALF_A = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SMAX_A = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0]  SMIN_A = -SMAX_A - ACC_W'(1);
    localparam logic signed [OP_W-1:0]   B24 = OP_W'(DIV24_BIAS);
    localparam logic signed [OP_W-1:0]   B6  = OP_W'(DIV6_BIAS);
    localparam logic signed [OP_W-1:0]   B4  = OP_W'(DIV4_BIAS);

    function automatic logic signed [OP_W-1:0] d_of(input logic signed [OP_W-1:0] fd,
                                                    input logic [K_W-1:0] k);
        logic signed [OP_W-1:0] off;
        off  = $signed(OP_W'(k) << FRAC_BITS);
        d_of = fd - off;
    endfunction

    t_state r_state;
    t_state n_state;

    logic signed [SAMPLE_WIDTH-1:0] r_ring [RING_DEPTH];
    logic [PTR_W-1:0]               r_ptr;
    logic [FILL_W-1:0]              r_fill;
    logic [STEP_W-1:0]              r_step;
    logic                           r_out_valid;

    logic signed [OP_W-1:0]   r_fd;
    logic signed [OP_W-1:0]   r_run;
    logic signed [OP_W-1:0]   r_p01;
    logic signed [OP_W-1:0]   r_p012;
    logic signed [ACC_W-1:0]  r_acc;
    logic [SAMPLE_WIDTH-1:0]  r_res;
    logic                     r_res_primed;
    logic [SAMPLE_WIDTH-1:0]  r_out_sample;
    logic                     r_out_primed;

    logic                           w_accept;
    logic                           w_unprimed;
    logic signed [SAMPLE_WIDTH-1:0] w_in_sample;
    logic [FRAC_IN_W-1:0]           w_in_frac;
    logic signed [OP_W-1:0]         w_frac_ext;
    t_uop                           w_uop;
    logic                           w_last_step;
    logic [PTR_W:0]                 w_sidx_sum;
    logic [PTR_W-1:0]               w_sidx;
    logic signed [OP_W-1:0]         w_mul_a;
    logic signed [OP_W-1:0]         w_mul_b;
    logic                           w_mul_start;
    logic                           w_mul_done;
    logic signed [PROD_W-1:0]       w_mul_prod;
    logic signed [PROD_W-1:0]       w_rnd_sum;
    logic signed [PROD_W-1:0]       w_rnd_full;
    logic signed [OP_W-1:0]         w_s24;
    logic signed [OP_W-1:0]         w_s6;
    logic signed [OP_W-1:0]         w_s4;
    logic signed [OP_W-1:0]         w_y24;
    logic signed [OP_W-1:0]         w_y6;
    logic signed [OP_W-1:0]         w_y4;
    logic                           w_div_start;
    logic                           w_div_done;
    logic signed [OP_W-1:0]         w_div_q;
    logic signed [ACC_W-1:0]        w_fin;
    logic                           w_out_load;

    assign w_in_sample = $signed(i_s_tdata[SAMPLE_WIDTH-1:0]);
    assign w_in_frac   = i_s_tdata[SAMPLE_WIDTH +: FRAC_IN_W];
    assign w_frac_ext  = $signed(OP_W'(w_in_frac));
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_unprimed  = (r_fill < FILL_W'(PRIME_COUNT));

    assign w_uop       = uop_rom(r_step);
    assign w_last_step = (r_step == STEP_W'(UOP_COUNT - 1));

    // The pointer already names the oldest sample, which takes weight h0.
    assign w_sidx_sum = {1'b0, r_ptr} + (PTR_W + 1)'(w_uop.weight);
    assign w_sidx     = (w_sidx_sum >= (PTR_W + 1)'(RING_DEPTH))
                      ? PTR_W'(w_sidx_sum - (PTR_W + 1)'(RING_DEPTH))
                      : w_sidx_sum[PTR_W-1:0];

    always_comb begin
        if (r_state == ST_MAC_GO) begin
            w_mul_a = r_run;
            w_mul_b = OP_W'(r_ring[w_sidx]);
        end else begin
            w_mul_b = d_of(r_fd, w_uop.b_k);
            if (!w_uop.first) begin
                w_mul_a = r_run;
            end else begin
                case (w_uop.asrc)
                    ASRC_D:    w_mul_a = d_of(r_fd, w_uop.a_k);
                    ASRC_P01:  w_mul_a = r_p01;
                    ASRC_P012: w_mul_a = r_p012;
                    default:   w_mul_a = r_run;
                endcase
            end
        end
    end

    lfd_serial_mul #(
        .OP_W (OP_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_prod)
    );

    assign w_rnd_sum  = w_mul_prod + HALF_P;
    assign w_rnd_full = w_rnd_sum >>> FRAC_BITS;

    // Rounded divide by 24, 6 or 4: the power-of-two part is a floor shift.
    assign w_s24 = r_run + B24;
    assign w_s6  = r_run + B6;
    assign w_s4  = r_run + B4;
    assign w_y24 = w_s24 >>> DIV24_SHIFT;
    assign w_y6  = w_s6 >>> DIV6_SHIFT;
    assign w_y4  = w_s4 >>> DIV4_SHIFT;

    lfd_div3 #(
        .OP_W (OP_W)
    ) u_div3 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ((w_uop.scale == SCALE_DIV24) ? w_y24 : w_y6),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_fin = r_acc >>> FRAC_BITS;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_unprimed ? ST_OUT : ST_MUL_GO;
                end
            end
            ST_MUL_GO:   n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: n_state = w_mul_done ? ST_ROUND : ST_MUL_WAIT;
            ST_ROUND:    n_state = w_uop.last ? ST_SCALE : ST_MUL_GO;
            ST_SCALE:    n_state = (w_uop.scale == SCALE_DIV4) ? ST_MAC_GO : ST_DIV_WAIT;
            ST_DIV_WAIT: n_state = w_div_done ? ST_MAC_GO : ST_DIV_WAIT;
            ST_MAC_GO:   n_state = ST_MAC_WAIT;
            ST_MAC_WAIT: n_state = w_mul_done ? ST_ACC : ST_MAC_WAIT;
            ST_ACC:      n_state = w_last_step ? ST_BIAS : ST_MUL_GO;
            ST_BIAS:     n_state = ST_CLAMP;
            ST_CLAMP:    n_state = ST_OUT;
            ST_OUT:      n_state = w_out_load ? ST_IDLE : ST_OUT;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:              o_s_tready  = 1'b1;
            ST_MUL_GO, ST_MAC_GO: w_mul_start = 1'b1;
            ST_SCALE:             w_div_start = (w_uop.scale != SCALE_DIV4);
            ST_OUT:               w_out_load  = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_ring[r_ptr] <= w_in_sample;
                r_ptr  <= (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + PTR_W'(1);
                r_step <= '0;
                if (w_unprimed) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end else if ((r_state == ST_ROUND && !w_uop.last) ||
                         (r_state == ST_ACC && !w_last_step)) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fd         <= (w_frac_ext < ONE_OP) ? w_frac_ext + ONE_OP : w_frac_ext;
            r_acc        <= '0;
            r_res        <= '0;
            r_res_primed <= 1'b0;
        end
        case (r_state)
            ST_ROUND: begin
                r_run <= w_rnd_full[OP_W-1:0];
                if (w_uop.save == SAVE_P01) begin
                    r_p01 <= w_rnd_full[OP_W-1:0];
                end
                if (w_uop.save == SAVE_P012) begin
                    r_p012 <= w_rnd_full[OP_W-1:0];
                end
            end
            ST_SCALE: begin
                if (w_uop.scale == SCALE_DIV4) begin
                    r_run <= w_y4;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    r_run <= (w_uop.scale == SCALE_DIV6_NEG) ? -w_div_q : w_div_q;
                end
            end
            ST_ACC:  r_acc <= r_acc + ACC_W'(w_mul_prod);
            ST_BIAS: r_acc <= r_acc + HALF_A;
            ST_CLAMP: begin
                r_res_primed <= 1'b1;
                if (w_fin > SMAX_A) begin
                    r_res <= SMAX_A[SAMPLE_WIDTH-1:0];
                end else if (w_fin < SMIN_A) begin
                    r_res <= SMIN_A[SAMPLE_WIDTH-1:0];
                end else begin
                    r_res <= w_fin[SAMPLE_WIDTH-1:0];
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_sample <= r_res;
            r_out_primed <= r_res_primed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_sample);
    assign o_m_tuser  = r_out_primed;

    a_unprimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_primed) |-> (r_out_sample == '0))
        else $error("unprimed result carries a nonzero sample");

    a_primed_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_primed) |-> (r_fill == FILL_W'(PRIME_COUNT)))
        else $error("computed result before four samples were taken");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < PTR_W'(RING_DEPTH))
        else $error("ring pointer out of range");

    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_MUL_WAIT || r_state == ST_MAC_WAIT))
        else $error("multiplier finished outside a wait state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
